@@ sv/spq_pkg.sv @@
// Shared types, codes and defaults for the strict-priority multi-FIFO queue.
// No dependencies; imported by every module of the block.
`default_nettype none
package spq_pkg;

    // Default sizes
    localparam int NODE_DEPTH_DEF = 1024;
    localparam int LEVELS_DEF     = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int PRIO_W   = 4;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 11;
    localparam int LIU_W    = 5;

    // Configuration register indexes
    localparam logic CFG_LEVELS_IN_USE  = 1'b0;
    localparam logic CFG_CAPACITY_LIMIT = 1'b1;

    // Configuration reset values
    localparam logic [LIU_W-1:0] LEVELS_IN_USE_RST  = 5'd10;
    localparam logic [CFG_W-1:0] CAPACITY_LIMIT_RST = 11'd1024;

    // Request modes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_PRI = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_INS  = 3'b010,
        S_REM  = 3'b100
    } state_t;

    // Commit controls for the level table
    typedef struct packed {
        logic ins;   // append node at level tail
        logic rem;   // pop level head
        logic last;  // popped node was the only one at its level
    } lvl_ctl_t;

endpackage
`default_nettype wire

@@ sv/spq_node_store.sv @@
// Node store: payload memory and link memory, registered synchronous reads.
// Depends on spq_pkg (imported for consistency of the house style).
`default_nettype none
module spq_node_store #(
    parameter int NODE_DEPTH = spq_pkg::NODE_DEPTH_DEF,
    parameter int DATA_WIDTH = spq_pkg::DATA_WIDTH_DEF,
    parameter int AW         = $clog2(NODE_DEPTH)
) (
    input  wire logic                  clk,
    input  wire logic                  rd_en,
    input  wire logic [AW-1:0]         rd_addr,
    output logic      [DATA_WIDTH-1:0] payload_q,
    output logic      [AW-1:0]         link_q,
    input  wire logic                  pay_we,
    input  wire logic [AW-1:0]         pay_addr,
    input  wire logic [DATA_WIDTH-1:0] pay_data,
    input  wire logic                  link_we,
    input  wire logic [AW-1:0]         link_addr,
    input  wire logic [AW-1:0]         link_data
);
    import spq_pkg::*;

    logic [DATA_WIDTH-1:0] payload_mem [NODE_DEPTH];
    logic [AW-1:0]         link_mem    [NODE_DEPTH];

    // Write and read the payload memory
    always_ff @(posedge clk)
    begin
        if (pay_we)
        begin
            payload_mem[pay_addr] <= pay_data;
        end
        if (rd_en)
        begin
            payload_q <= payload_mem[rd_addr];
        end
    end

    // Write and read the link memory
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_addr] <= link_data;
        end
        if (rd_en)
        begin
            link_q <= link_mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ sv/spq_level_table.sv @@
// Per-level head/tail pointers, non-empty flags and the most-urgent-level encoder.
// Depends on spq_pkg for lvl_ctl_t.
`default_nettype none
module spq_level_table #(
    parameter int LEVELS = spq_pkg::LEVELS_DEF,
    parameter int AW     = $clog2(spq_pkg::NODE_DEPTH_DEF),
    parameter int LW     = $clog2(LEVELS)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire spq_pkg::lvl_ctl_t ctl,
    input  wire logic [LW-1:0]    lvl,
    input  wire logic [AW-1:0]    node,
    input  wire logic [AW-1:0]    next_head,
    output logic      [AW-1:0]    head_q,
    output logic      [AW-1:0]    tail_q,
    output logic      [LEVELS-1:0] nonempty,
    output logic      [LW-1:0]    best,
    output logic                  any
);
    import spq_pkg::*;

    logic [AW-1:0]     head_reg [LEVELS];
    logic [AW-1:0]     tail_reg [LEVELS];
    logic [LEVELS-1:0] ne_reg;
    logic [LEVELS-1:0] ne_next;

    assign head_q   = head_reg[lvl];
    assign tail_q   = tail_reg[lvl];
    assign nonempty = ne_reg;
    assign any      = |ne_reg;

    // Pick the lowest non-empty level
    always_comb
    begin
        best = '0;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (ne_reg[i])
            begin
                best = LW'(i);
            end
        end
    end

    // Update the non-empty flags
    always_comb
    begin
        ne_next = ne_reg;
        if (ctl.ins)
        begin
            ne_next[lvl] = 1'b1;
        end
        else if (ctl.rem && ctl.last)
        begin
            ne_next[lvl] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ne_reg <= '0;
        end
        else
        begin
            ne_reg <= ne_next;
        end
    end

    // Move head and tail pointers on commit
    always_ff @(posedge clk)
    begin
        if (ctl.ins)
        begin
            tail_reg[lvl] <= node;
            if (!ne_reg[lvl])
            begin
                head_reg[lvl] <= node;
            end
        end
        else if (ctl.rem && !ctl.last)
        begin
            head_reg[lvl] <= next_head;
        end
    end

endmodule
`default_nettype wire

@@ sv/strict_priority_multi_fifo_queue_unit.sv @@
// Top level of the strict-priority multi-FIFO queue: sequencer, free list, config.
// Depends on spq_pkg, spq_node_store and spq_level_table.
//
// A request is taken when start is high and busy is low. An accepted insert or
// a remove that finds an entry takes two steps: the first reads the node store
// (link and payload memories, registered reads), the second writes the links
// back and commits the level pointers. The result strobe done rises in the
// cycle after that, together with busy going low, so a new request can be
// taken in the same cycle the result is shown. A refused insert or a remove
// on an empty queue is answered from the idle state without a node store read.
// The result is held for exactly one cycle; the receiver cannot stall it. No
// clearing pass is needed after reset: a fill mark stands in for the reset
// chain of the free list. Configuration writes are meant for idle periods only.
`default_nettype none
module strict_priority_multi_fifo_queue_unit #(
    parameter int NODE_DEPTH = spq_pkg::NODE_DEPTH_DEF,
    parameter int LEVELS     = spq_pkg::LEVELS_DEF,
    parameter int DATA_WIDTH = spq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          mode,
    input  wire logic [spq_pkg::PRIO_W-1:0]    priority_req,
    input  wire logic [DATA_WIDTH-1:0]         data_in,
    output logic                               done,
    output logic      [spq_pkg::STATUS_W-1:0]  status,
    output logic      [DATA_WIDTH-1:0]         data_out,
    output logic      [spq_pkg::PRIO_W-1:0]    level_out,
    input  wire logic                          cfg_wr_en,
    input  wire logic                          cfg_index,
    input  wire logic [spq_pkg::CFG_W-1:0]     cfg_wdata
);
    import spq_pkg::*;

    localparam int AW = $clog2(NODE_DEPTH);
    localparam int LW = $clog2(LEVELS);
    localparam int CW = AW + 1;

    state_t state_reg, state_next;

    logic [LIU_W-1:0]      liu_reg;
    logic [CFG_W-1:0]      cap_reg;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         fresh_reg, fresh_next;
    logic [AW-1:0]         free_head_reg, free_head_next;
    logic [AW-1:0]         node_reg, node_next;
    logic [LW-1:0]         lvl_reg, lvl_next;

    logic                  done_reg, done_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [DATA_WIDTH-1:0] dout_reg, dout_next;
    logic [PRIO_W-1:0]     lout_reg, lout_next;

    logic                  accept;
    logic                  full;
    logic                  bad_pri;
    logic [LW+PRIO_W-1:0]  prio_wide;
    logic [LW-1:0]         prio_idx;
    logic [LW+PRIO_W-1:0]  lvl_wide;
    logic [CW-1:0]         node_inc;
    logic                  untouched;
    logic [AW-1:0]         link_val;

    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] payload_q;
    logic [AW-1:0]         link_q;
    logic                  pay_we;
    logic                  link_we;
    logic [AW-1:0]         link_addr;
    logic [AW-1:0]         link_data;

    lvl_ctl_t              ctl;
    logic [LW-1:0]         tbl_lvl;
    logic [AW-1:0]         head_q;
    logic [AW-1:0]         tail_q;
    logic [LEVELS-1:0]     nonempty;
    logic [LW-1:0]         best;
    logic                  any;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign done      = done_reg;
    assign status    = status_reg;
    assign data_out  = dout_reg;
    assign level_out = lout_reg;

    // Request checks
    assign full      = (32'(count_reg) >= 32'(cap_reg)) || (32'(count_reg) >= 32'(NODE_DEPTH));
    assign bad_pri   = ({1'b0, priority_req} >= liu_reg)
                       || (32'(priority_req) >= 32'(LEVELS));
    assign prio_wide = {{LW{1'b0}}, priority_req};
    assign prio_idx  = prio_wide[LW-1:0];
    assign lvl_wide  = {{PRIO_W{1'b0}}, lvl_reg};

    // Link of a node never written continues the reset chain
    assign node_inc  = {1'b0, node_reg} + CW'(1);
    assign untouched = ({1'b0, node_reg} >= fresh_reg);
    assign link_val  = untouched ? ((node_inc == CW'(NODE_DEPTH)) ? '0 : node_inc[AW-1:0])
                                 : link_q;

    assign tbl_lvl   = busy ? lvl_reg : best;
    assign pay_we    = accept && (mode == MODE_INSERT) && !full && !bad_pri;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        fresh_next     = fresh_reg;
        free_head_next = free_head_reg;
        node_next      = node_reg;
        lvl_next       = lvl_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        dout_next      = dout_reg;
        lout_next      = lout_reg;
        rd_en          = 1'b0;
        rd_addr        = free_head_reg;
        link_we        = 1'b0;
        link_addr      = node_reg;
        link_data      = free_head_reg;
        ctl            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    dout_next = '0;
                    lout_next = '0;
                    if (mode == MODE_INSERT)
                    begin
                        if (full)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_FULL;
                        end
                        else if (bad_pri)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_BAD_PRI;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = free_head_reg;
                            node_next  = free_head_reg;
                            lvl_next   = prio_idx;
                            state_next = S_INS;
                        end
                    end
                    else if (!any)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = head_q;
                        node_next  = head_q;
                        lvl_next   = best;
                        state_next = S_REM;
                    end
                end
            end
            S_INS:
            begin
                // Pop free list, append node behind the level tail
                free_head_next = link_val;
                if (untouched)
                begin
                    fresh_next = fresh_reg + CW'(1);
                end
                link_we     = nonempty[lvl_reg];
                link_addr   = tail_q;
                link_data   = node_reg;
                ctl.ins     = 1'b1;
                count_next  = count_reg + CW'(1);
                done_next   = 1'b1;
                status_next = ST_OK;
                state_next  = S_IDLE;
            end
            S_REM:
            begin
                // Advance level head, push node onto the free list
                ctl.rem        = 1'b1;
                ctl.last       = (node_reg == tail_q);
                link_we        = 1'b1;
                link_addr      = node_reg;
                link_data      = free_head_reg;
                free_head_next = node_reg;
                count_next     = count_reg - CW'(1);
                done_next      = 1'b1;
                status_next    = ST_OK;
                dout_next      = payload_q;
                lout_next      = lvl_wide[PRIO_W-1:0];
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            fresh_reg     <= '0;
            free_head_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            fresh_reg     <= fresh_next;
            free_head_reg <= free_head_next;
            done_reg      <= done_next;
        end
    end

    // Hold request context and result payload
    always_ff @(posedge clk)
    begin
        node_reg   <= node_next;
        lvl_reg    <= lvl_next;
        status_reg <= status_next;
        dout_reg   <= dout_next;
        lout_reg   <= lout_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            liu_reg <= LEVELS_IN_USE_RST;
            cap_reg <= CAPACITY_LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_LEVELS_IN_USE:  liu_reg <= cfg_wdata[LIU_W-1:0];
                CFG_CAPACITY_LIMIT: cap_reg <= cfg_wdata;
                default:            cap_reg <= cap_reg;
            endcase
        end
    end

    spq_node_store #(
        .NODE_DEPTH (NODE_DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_nodes (
        .clk       (clk),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .payload_q (payload_q),
        .link_q    (link_q),
        .pay_we    (pay_we),
        .pay_addr  (free_head_reg),
        .pay_data  (data_in),
        .link_we   (link_we),
        .link_addr (link_addr),
        .link_data (link_data)
    );

    spq_level_table #(
        .LEVELS (LEVELS),
        .AW     (AW),
        .LW     (LW)
    ) u_levels (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .lvl       (tbl_lvl),
        .node      (node_reg),
        .next_head (link_q),
        .head_q    (head_q),
        .tail_q    (tail_q),
        .nonempty  (nonempty),
        .best      (best),
        .any       (any)
    );

    // Checks
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (state_reg == S_IDLE))
        else $error("result shown while a request is in flight");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(NODE_DEPTH))
        else $error("entry count above node depth");

    a_accept_ends: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (done || busy))
        else $error("accepted request gave no result");

    a_empty_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ((count_reg == '0) == (nonempty == '0)))
        else $error("entry count disagrees with level flags");

endmodule
`default_nettype wire

@@ test/tb.sv @@
// Testbench for strict_priority_multi_fifo_queue_unit: directed and random requests.
// Depends on spq_pkg and the RTL; a scoreboard class predicts each result.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import spq_pkg::*;

    localparam int DEPTH = NODE_DEPTH_DEF;
    localparam int NLVL  = LEVELS_DEF;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [31:0]         data;
        logic [PRIO_W-1:0]   level;
    } qres_t;

    // Queue model: one FIFO per level, plus a queue of pending results
    class queue_scoreboard;
        logic [31:0]  level_fifo[NLVL][$];
        int           held;
        logic [4:0]   levels_cfg;
        logic [10:0]  cap_cfg;
        qres_t        pending[$];
        int           errors;

        function void clear();
            for (int i = 0; i < NLVL; i++) level_fifo[i].delete();
            held = 0;
            levels_cfg = LEVELS_IN_USE_RST;
            cap_cfg = CAPACITY_LIMIT_RST;
            pending.delete();
            errors = 0;
        endfunction

        function void set_reg(logic idx, logic [10:0] val);
            if (idx == CFG_LEVELS_IN_USE) levels_cfg = val[4:0];
            else cap_cfg = val;
        endfunction

        // Compute and hold the result of an accepted request
        function void note_request(logic m, logic [3:0] p, logic [31:0] d);
            qres_t r;
            int lim;
            r = '0;
            lim = (levels_cfg > NLVL) ? NLVL : levels_cfg;
            if (m == MODE_INSERT) begin
                if (held >= cap_cfg || held >= DEPTH) r.status = ST_FULL;
                else if (p >= lim) r.status = ST_BAD_PRI;
                else
                begin
                    level_fifo[p].push_back(d);
                    held++;
                    r.status = ST_OK;
                end
            end
            else
            begin
                r.status = ST_EMPTY;
                for (int i = 0; i < NLVL; i++)
                begin
                    if (level_fifo[i].size() > 0)
                    begin
                        r.status = ST_OK;
                        r.data = level_fifo[i].pop_front();
                        r.level = PRIO_W'(i);
                        held--;
                        break;
                    end
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(qres_t got);
            qres_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result status=%0d", got.status);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (e.status !== got.status)
            begin
                $error("status: expected %0d, got %0d", e.status, got.status);
                errors++;
            end
            if (e.data !== got.data)
            begin
                $error("data_out: expected %h, got %h", e.data, got.data);
                errors++;
            end
            if (e.level !== got.level)
            begin
                $error("level_out: expected %0d, got %0d", e.level, got.level);
                errors++;
            end
        endfunction
    endclass

    logic clk, rst_n, start, mode, cfg_wr_en, cfg_index;
    logic [3:0]  priority_req;
    logic [31:0] data_in;
    logic [10:0] cfg_wdata;
    logic busy, done;
    logic [1:0]  status;
    logic [31:0] data_out;
    logic [3:0]  level_out;

    queue_scoreboard sb;

    strict_priority_multi_fifo_queue_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .priority_req(priority_req), .data_in(data_in), .done(done),
        .status(status), .data_out(data_out), .level_out(level_out),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Check every strobed result
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result('{status, data_out, level_out});
    end

    // Issue one request, hold start until accepted
    task automatic send_request(logic m, logic [3:0] p, logic [31:0] d);
        start <= 1'b1;
        mode <= m;
        priority_req <= p;
        data_in <= d;
        do @(posedge clk); while (busy);
        sb.note_request(m, p, d);
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Wait until every expected result has come, plus settle time
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() > 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write one register, then drop the write enable before returning
    task automatic write_reg(logic idx, logic [10:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    // Mostly well-formed mixes with random content
    task automatic random_phase(int count, int ins_pct);
        for (int i = 0; i < count; i++)
        begin
            send_request($urandom_range(0, 99) >= ins_pct, 4'($urandom_range(0, 15)),
                         $urandom);
            if (i < count - 1 && $urandom_range(0, 3) == 0) idle_gap();
        end
        drain();
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        rst_n = 1'b0;
        start = 1'b0;
        mode = MODE_INSERT;
        priority_req = '0;
        data_in = '0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_LEVELS_IN_USE;
        cfg_wdata = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty remove, extremes, bad priority, FIFO order, priority
        send_request(MODE_REMOVE, 4'hF, 32'hFFFF_FFFF);
        send_request(MODE_INSERT, 4'd9, 32'hFFFF_FFFF);
        send_request(MODE_INSERT, 4'd10, 32'h1234_5678);
        send_request(MODE_INSERT, 4'd15, 32'h0);
        send_request(MODE_INSERT, 4'd0, 32'h0);
        send_request(MODE_INSERT, 4'd9, 32'hA5A5_5A5A);
        send_request(MODE_INSERT, 4'd0, 32'h5A5A_A5A5);
        repeat (5) send_request(MODE_REMOVE, 4'd0, 32'h0);
        drain();

        // Capacity zero refuses, then small cap
        write_reg(CFG_CAPACITY_LIMIT, 11'd0);
        send_request(MODE_INSERT, 4'd1, 32'hDEAD_BEEF);
        drain();
        write_reg(CFG_CAPACITY_LIMIT, 11'd3);
        write_reg(CFG_LEVELS_IN_USE, 5'd16);
        repeat (5) send_request(MODE_INSERT, 4'd15, $urandom);
        drain();
        // Lower limit below count and levels below stored levels
        write_reg(CFG_CAPACITY_LIMIT, 11'd1);
        write_reg(CFG_LEVELS_IN_USE, 5'd0);
        send_request(MODE_INSERT, 4'd0, 32'h1);
        repeat (4) send_request(MODE_REMOVE, 4'd0, 32'h0);
        send_request(MODE_INSERT, 4'd0, 32'h1);
        drain();
        write_reg(CFG_LEVELS_IN_USE, 5'd31);
        write_reg(CFG_CAPACITY_LIMIT, 11'd2047);

        // Random phases across settings
        random_phase(300, 60);
        write_reg(CFG_LEVELS_IN_USE, 5'd1);
        write_reg(CFG_CAPACITY_LIMIT, 11'd8);
        random_phase(200, 55);
        write_reg(CFG_LEVELS_IN_USE, 5'd4);
        write_reg(CFG_CAPACITY_LIMIT, 11'd1024);
        random_phase(200, 50);
        write_reg(CFG_LEVELS_IN_USE, 5'd10);
        write_reg(CFG_CAPACITY_LIMIT, 11'd20);
        random_phase(300, 50);

        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
`default_nettype wire

@@ sim.f @@
sv/spq_pkg.sv
sv/spq_node_store.sv
sv/spq_level_table.sv
sv/strict_priority_multi_fifo_queue_unit.sv
test/tb.sv
